// File: hw/rtl/hbp_pkg.sv
// hbp_pkg: constants and types shared by the huffman bit packer
// no dependencies; compiled first
`default_nettype none

package hbp_pkg;

	localparam int MAX_CODE_LEN = 32;
	localparam int CODE_W       = 32;
	localparam int LEN_CAP      = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
	localparam int LEN_W        = 6;
	localparam int SYM_W        = 8;
	localparam int NUM_SYM      = 1 << SYM_W;
	localparam int BYTE_W       = 8;
	localparam int PEND_W       = BYTE_W - 1;
	localparam int BUF_W        = PEND_W + CODE_W;
	localparam int CNT_W        = $clog2(BUF_W + 1);

	localparam logic ACT_LOAD   = 1'b0;
	localparam logic ACT_ENCODE = 1'b1;

	typedef logic [SYM_W-1:0]  sym_t;
	typedef logic [CODE_W-1:0] word_t;
	typedef logic [LEN_W-1:0]  len_t;
	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [BUF_W-1:0]  pbuf_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	typedef struct packed {
		len_t  len;
		word_t word;
	} entry_t;

endpackage

`default_nettype wire

// File: hw/rtl/hbp_in_if.sv
// hbp_in_if: valid/ready channel carrying load and encode items
// depends on hbp_pkg
`default_nettype none

interface hbp_in_if;
	logic               valid;
	logic               ready;
	logic               action;
	hbp_pkg::sym_t      symbol;
	hbp_pkg::word_t     code_value;
	hbp_pkg::len_t      code_length;
	logic               end_of_block;

	modport source (
		output valid, action, symbol, code_value, code_length, end_of_block,
		input  ready
	);
	modport sink (
		input  valid, action, symbol, code_value, code_length, end_of_block,
		output ready
	);
endinterface

`default_nettype wire

// File: hw/rtl/hbp_out_if.sv
// hbp_out_if: valid/ready channel carrying packed output bytes
// depends on hbp_pkg
`default_nettype none

interface hbp_out_if;
	logic           valid;
	logic           ready;
	hbp_pkg::byte_t packed_byte;
	logic           last_of_run;
	logic           block_done;

	modport source (
		output valid, packed_byte, last_of_run, block_done,
		input  ready
	);
	modport sink (
		input  valid, packed_byte, last_of_run, block_done,
		output ready
	);
endinterface

`default_nettype wire

// File: hw/rtl/huffman_bit_packer_top.sv
// huffman_bit_packer_top: code table memory, lookup pipeline and byte packer
// depends on hbp_pkg, hbp_in_if, hbp_out_if
//
//   channel  dir  payload                                                   per transaction
//   item     in   action, symbol, code_value, code_length, end_of_block    one load or encode
//   result   out  packed_byte, last_of_run, block_done                     one output byte
//
// an encode item holds the packer while it makes its output bytes (0 to 5);
// a load writes the table memory directly and does not enter the packer
// the first byte of an encode passes the table read, align and pack stages and the output register
// the table read port, the single-entry packer and the output register set the pace
// reset clears the length valid bits, pending bits and all handshake state; no clearing pass
// a stalled result holds the packer, which backs up through the align and read stages
`default_nettype none

module huffman_bit_packer_top (
	input  logic       clk,
	input  logic       arst_n,
	hbp_in_if.sink     item,
	hbp_out_if.source  result
);
	import hbp_pkg::*;

	// code table: word and length in one memory, valid bits stand in for the length reset
	entry_t             table_mem [NUM_SYM];
	logic [NUM_SYM-1:0] len_valid_q;

	logic   item_acc, load_acc, enc_acc;
	len_t   load_len;

	// read stage
	logic   valid_s1, hit_s1, eob_s1;
	entry_t rd_entry_s1;
	len_t   clen_s1;
	word_t  code_al_s1;
	logic   s1_adv;

	// align stage
	logic   valid_s2, eob_s2;
	len_t   clen_s2;
	word_t  code_al_s2;
	logic   s2_ready, s2_take;

	// packer
	pbuf_t  pend_buf_q;
	cnt_t   cnt_q;
	logic   active_q, eob_q;
	logic   has_full, fin, pend_pad, emit, out_adv, pk_free;
	pbuf_t  post_buf, base_buf, merged_buf;
	cnt_t   post_cnt, base_cnt, merged_cnt;
	logic   merged_active;

	// output register
	logic   out_valid_q, last_q, done_q;
	byte_t  byte_q;

	assign item_acc = item.valid && item.ready;
	assign load_acc = item_acc && (item.action == ACT_LOAD);
	assign enc_acc  = item_acc && (item.action == ACT_ENCODE);
	assign load_len = (item.code_length > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : item.code_length;

	assign s2_ready   = !valid_s2 || s2_take;
	assign s1_adv     = valid_s1 && s2_ready;
	assign item.ready = !valid_s1 || s2_ready;

	always_ff @(posedge clk) begin
		if (load_acc) begin
			table_mem[item.symbol] <= {load_len, item.code_value};
		end
		if (enc_acc) begin
			rd_entry_s1 <= table_mem[item.symbol];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_valid_q <= '0;
		end else if (load_acc) begin
			len_valid_q[item.symbol] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (enc_acc) begin
			hit_s1 <= len_valid_q[item.symbol];
			eob_s1 <= item.end_of_block;
		end
	end

	// left-align the code so its first bit sits at the top; zero length gives no bits
	assign clen_s1    = hit_s1 ? rd_entry_s1.len : '0;
	assign code_al_s1 = (clen_s1 == '0) ? '0 :
		(rd_entry_s1.word << (LEN_W'(CODE_W) - clen_s1));

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			clen_s2    <= clen_s1;
			code_al_s2 <= code_al_s1;
			eob_s2     <= eob_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (item.ready) begin
				valid_s1 <= enc_acc;
			end
			if (s2_ready) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// packer: bits kept msb-aligned in pend_buf_q, everything below cnt_q is zero
	assign out_adv  = !out_valid_q || result.ready;
	assign emit     = active_q && out_adv;
	assign has_full = cnt_q >= CNT_W'(BYTE_W);
	assign post_buf = has_full ? (pend_buf_q << BYTE_W) : '0;
	assign post_cnt = has_full ? (cnt_q - CNT_W'(BYTE_W)) : '0;
	assign pend_pad = eob_q && (post_cnt != '0);
	assign fin      = (post_cnt < CNT_W'(BYTE_W)) && !pend_pad;
	assign pk_free  = !active_q || (out_adv && fin);
	assign s2_take  = valid_s2 && pk_free;

	// merge the next code behind the remainder left by this cycle's byte
	assign base_buf      = active_q ? post_buf : pend_buf_q;
	assign base_cnt      = active_q ? post_cnt : cnt_q;
	assign merged_buf    = base_buf | ({code_al_s2, {PEND_W{1'b0}}} >> base_cnt[2:0]);
	assign merged_cnt    = base_cnt + CNT_W'(clen_s2);
	assign merged_active = (merged_cnt >= CNT_W'(BYTE_W)) || (eob_s2 && (merged_cnt != '0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_buf_q <= '0;
			cnt_q      <= '0;
			active_q   <= 1'b0;
			eob_q      <= 1'b0;
		end else if (s2_take) begin
			pend_buf_q <= merged_buf;
			cnt_q      <= merged_cnt;
			active_q   <= merged_active;
			eob_q      <= eob_s2;
		end else if (emit) begin
			pend_buf_q <= post_buf;
			cnt_q      <= post_cnt;
			active_q   <= !fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_adv) begin
			out_valid_q <= active_q;
		end
	end

	// top byte is either a full byte or the zero-padded tail
	always_ff @(posedge clk) begin
		if (emit) begin
			byte_q <= pend_buf_q[BUF_W-1 -: BYTE_W];
			last_q <= fin;
			done_q <= fin && eob_q;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.packed_byte = byte_q;
	assign result.last_of_run = last_q;
	assign result.block_done  = done_q;

	a_active_has_bits: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (cnt_q != '0))
		else $error("packer active with no pending bits");

	a_idle_partial: assert property (@(posedge clk) disable iff (!arst_n)
		!active_q |-> (cnt_q < CNT_W'(BYTE_W)))
		else $error("packer idle with a full byte pending");

	a_buf_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_buf_q << cnt_q) == '0)
		else $error("stale bits below pending count");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(BUF_W))
		else $error("pending count beyond buffer width");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && done_q) |-> last_q)
		else $error("block done without last of run");

endmodule

`default_nettype wire

// File: sim/tb.sv
// tb: self-checking testbench for huffman_bit_packer_top, table loads and encodes
// depends on hbp_pkg, hbp_in_if, hbp_out_if and the huffman_bit_packer_top rtl

module tb;
	import hbp_pkg::*;

	typedef struct {
		logic  action;
		sym_t  symbol;
		word_t code_value;
		len_t  code_length;
		logic  end_of_block;
	} packer_item_t;

	typedef struct {
		byte_t data;
		logic  last;
		logic  done;
	} out_byte_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// interface inputs held in local variables so they are known from time zero
	logic  in_valid  = 1'b0;
	logic  in_action = ACT_LOAD;
	sym_t  in_symbol = '0;
	word_t in_value  = '0;
	len_t  in_length = '0;
	logic  in_eob    = 1'b0;
	logic  out_ready = 1'b0;

	hbp_in_if  item_ch ();
	hbp_out_if result_ch ();

	assign item_ch.valid        = in_valid;
	assign item_ch.action       = in_action;
	assign item_ch.symbol       = in_symbol;
	assign item_ch.code_value   = in_value;
	assign item_ch.code_length  = in_length;
	assign item_ch.end_of_block = in_eob;
	assign result_ch.ready      = out_ready;

	huffman_bit_packer_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	always #5 clk = ~clk;

	// predictor state: code table and the bits not yet emitted
	word_t           table_word [NUM_SYM];
	len_t            table_len  [NUM_SYM];
	logic [PEND_W-1:0] pend_bits;
	logic [2:0]      pend_count;

	packer_item_t pending_items [$];
	out_byte_t    expected_bytes [$];
	packer_item_t next_item;
	out_byte_t    want;
	sym_t         hot_sym [16];

	int unsigned errors     = 0;
	int unsigned bytes_seen = 0;
	int unsigned cyc        = 0;
	int unsigned send_gap   = 0;
	int unsigned recv_gap   = 0;
	int unsigned stall_left = 0;
	logic        long_stall_done = 1'b0;

	always @(posedge clk) cyc <= cyc + 1;

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp_val);
		errors++;
		$display("mismatch %s: got %0h, expected %0h (byte %0d)", what, got, exp_val, bytes_seen);
	endtask

	// most gaps are short, a few long, and some stretches have none at all
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (cyc[8:7] == 2'b11) return 0;
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 30);
	endfunction

	function automatic len_t pick_length();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 10) return '0;
		if (r < 20) return len_t'($urandom_range(33, 63));
		if (r < 35) return len_t'($urandom_range(17, 32));
		return len_t'($urandom_range(1, 16));
	endfunction

	task automatic pack_item(input packer_item_t it);
		logic [63:0] acc;
		int          total;
		int          clen;
		out_byte_t   run [$];
		out_byte_t   ob;
		if (it.action == ACT_LOAD) begin
			table_word[it.symbol] = it.code_value;
			table_len[it.symbol]  = (it.code_length > LEN_CAP) ? len_t'(LEN_CAP) : it.code_length;
		end else begin
			clen  = table_len[it.symbol];
			total = pend_count;
			acc   = 64'(pend_bits);
			if (clen != 0) begin
				acc   = (acc << clen) | (64'(table_word[it.symbol]) & ((64'd1 << clen) - 64'd1));
				total = total + clen;
			end
			while (total >= 8) begin
				ob.data = byte_t'(acc >> (total - 8));
				ob.last = 1'b0;
				ob.done = 1'b0;
				run.push_back(ob);
				total = total - 8;
			end
			acc = acc & ((64'd1 << total) - 64'd1);
			// flush pads the leftover bits with zeros
			if (it.end_of_block && total != 0) begin
				ob.data = byte_t'(acc << (8 - total));
				ob.last = 1'b0;
				ob.done = 1'b0;
				run.push_back(ob);
				total = 0;
				acc   = '0;
			end
			pend_bits  = acc[PEND_W-1:0];
			pend_count = total[2:0];
			if (run.size() != 0) begin
				run[run.size()-1].last = 1'b1;
				run[run.size()-1].done = it.end_of_block;
			end
			foreach (run[i]) expected_bytes.push_back(run[i]);
		end
	endtask

	task automatic add_item(input logic act, input sym_t sym, input word_t val,
			input len_t len, input logic eob);
		packer_item_t it;
		it.action       = act;
		it.symbol       = sym;
		it.code_value   = val;
		it.code_length  = len;
		it.end_of_block = eob;
		pending_items.push_back(it);
	endtask

	// driver: predicts on each accepted transaction, then offers the next item
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap <= 0;
		end else begin
			if (in_valid && item_ch.ready) begin
				next_item.action       = in_action;
				next_item.symbol       = in_symbol;
				next_item.code_value   = in_value;
				next_item.code_length  = in_length;
				next_item.end_of_block = in_eob;
				pack_item(next_item);
			end
			if (!in_valid || item_ch.ready) begin
				if (send_gap != 0 && stall_left == 0) begin
					in_valid <= 1'b0;
					send_gap <= send_gap - 1;
				end else if (pending_items.size() != 0) begin
					next_item = pending_items.pop_front();
					in_valid  <= 1'b1;
					in_action <= next_item.action;
					in_symbol <= next_item.symbol;
					in_value  <= next_item.code_value;
					in_length <= next_item.code_length;
					in_eob    <= next_item.end_of_block;
					send_gap  <= pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver ready, with one long hold-off once output is flowing
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready       <= 1'b0;
			recv_gap        <= 0;
			stall_left      <= 0;
			long_stall_done <= 1'b0;
		end else if (stall_left != 0) begin
			out_ready  <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!long_stall_done && bytes_seen >= 20) begin
			out_ready       <= 1'b0;
			stall_left      <= 150;
			long_stall_done <= 1'b1;
		end else if (recv_gap != 0) begin
			out_ready <= 1'b0;
			recv_gap  <= recv_gap - 1;
		end else begin
			out_ready <= 1'b1;
			if (result_ch.valid && out_ready) recv_gap <= pick_gap();
		end
	end

	// monitor: compare each accepted byte with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && result_ch.valid && out_ready) begin
			if (expected_bytes.size() == 0) begin
				report("unexpected byte", 32'(result_ch.packed_byte), '0);
			end else begin
				want = expected_bytes.pop_front();
				if (result_ch.packed_byte !== want.data)
					report("packed_byte", 32'(result_ch.packed_byte), 32'(want.data));
				if (result_ch.last_of_run !== want.last)
					report("last_of_run", 32'(result_ch.last_of_run), 32'(want.last));
				if (result_ch.block_done !== want.done)
					report("block_done", 32'(result_ch.block_done), 32'(want.done));
			end
			bytes_seen <= bytes_seen + 1;
		end
	end

	initial begin
		int unsigned r;
		sym_t        sym;
		pend_bits  = '0;
		pend_count = '0;
		foreach (table_len[i]) table_len[i] = '0;

		// directed part
		add_item(ACT_ENCODE, 8'h00, '0, '0, 1'b1);              // empty flush on a fresh table
		add_item(ACT_LOAD, 8'h00, 32'hFFFF_FFFF, 6'd32, 1'b1);  // eob ignored on a load
		add_item(ACT_LOAD, 8'hFF, 32'h0000_0000, 6'd1, 1'b0);
		add_item(ACT_LOAD, 8'h5A, 32'h0000_00A5, 6'd8, 1'b0);
		add_item(ACT_LOAD, 8'h3C, 32'h9ABC_DEF1, 6'd63, 1'b0);  // saturates at the cap
		add_item(ACT_LOAD, 8'h11, 32'hDEAD_BEEF, 6'd0, 1'b0);   // no code
		add_item(ACT_LOAD, 8'h22, 32'h0000_0005, 6'd3, 1'b0);
		add_item(ACT_ENCODE, 8'hFF, '0, '0, 1'b0);
		add_item(ACT_ENCODE, 8'h00, '0, '0, 1'b0);
		add_item(ACT_ENCODE, 8'h3C, '0, '0, 1'b0);
		add_item(ACT_ENCODE, 8'h11, '0, '0, 1'b1);              // no bits but still flushes
		add_item(ACT_ENCODE, 8'h5A, '0, '0, 1'b0);
		add_item(ACT_ENCODE, 8'h5A, 32'hFFFF_FFFF, 6'd63, 1'b1); // block ends on a full byte
		add_item(ACT_ENCODE, 8'h22, '0, '0, 1'b0);
		add_item(ACT_ENCODE, 8'h22, '0, '0, 1'b0);
		add_item(ACT_ENCODE, 8'h22, '0, '0, 1'b1);
		add_item(ACT_ENCODE, 8'h11, '0, '0, 1'b1);              // empty flush
		add_item(ACT_ENCODE, 8'h22, '0, '0, 1'b0);
		add_item(ACT_ENCODE, 8'h22, '0, '0, 1'b0);
		add_item(ACT_ENCODE, 8'hFF, '0, '0, 1'b0);
		add_item(ACT_ENCODE, 8'h00, '0, '0, 1'b0);              // seven pending plus 32 bits
		add_item(ACT_ENCODE, 8'h00, '0, '0, 1'b1);              // five bytes from one item

		// random part: a hot set of loaded symbols carries most encodes
		foreach (hot_sym[i]) begin
			hot_sym[i] = sym_t'($urandom_range(0, 255));
			add_item(ACT_LOAD, hot_sym[i], $urandom, pick_length(), 1'($urandom_range(0, 1)));
		end
		for (int i = 0; i < 71; i++) begin
			r   = $urandom_range(0, 99);
			sym = ($urandom_range(0, 99) < 80) ? hot_sym[$urandom_range(0, 15)]
				: sym_t'($urandom_range(0, 255));
			if (r < 20)
				add_item(ACT_LOAD, sym, $urandom, pick_length(), 1'($urandom_range(0, 1)));
			else
				add_item(ACT_ENCODE, sym, $urandom, len_t'($urandom_range(0, 63)),
					$urandom_range(0, 99) < 12);
		end
		add_item(ACT_ENCODE, hot_sym[0], '0, '0, 1'b1);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_items.size() != 0 || in_valid) @(posedge clk);
		while (expected_bytes.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

// File: huffman_bit_packer_top.f
hw/rtl/hbp_pkg.sv
hw/rtl/hbp_in_if.sv
hw/rtl/hbp_out_if.sv
hw/rtl/huffman_bit_packer_top.sv
sim/tb.sv
